### src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/rrp_pkg.sv
// Package for the RGB rescale and pixel pack block: widths, stage counts,
// and the mask decode and division step functions. No dependencies.
`timescale 1ns / 1ps
package rrp_pkg;
	localparam int EXT_W      = 16;
	localparam int PIX_W      = 32;
	localparam int PROD_W     = EXT_W + PIX_W;
	localparam int SHIFT_W    = $clog2(PIX_W);
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = PIX_W / DIV_BITS;
	localparam int LAT        = DIV_STAGES + 2;
	localparam int IDX_W      = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_RED_MASK   = 3'd0,
		REG_GREEN_MASK = 3'd1,
		REG_BLUE_MASK  = 3'd2,
		REG_RED_FS     = 3'd3,
		REG_GREEN_FS   = 3'd4,
		REG_BLUE_FS    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] shift;
		logic [PIX_W-1:0]   maxv;
	} field_t;

	typedef struct packed {
		logic [EXT_W-1:0]    rem;
		logic [DIV_BITS-1:0] qbits;
	} div_step_t;

	// Trailing-zero count and the lowest run of ones, right aligned.
	function automatic field_t decode_mask(input logic [PIX_W-1:0] mask);
		field_t f;
		logic [PIX_W-1:0] low;
		logic [PIX_W:0]   sum;
		logic [PIX_W-1:0] run;
		f.shift = '0;
		for (int i = PIX_W - 1; i >= 0; i--) begin
			if (mask[i]) f.shift = SHIFT_W'(i);
		end
		low    = mask & (~mask + PIX_W'(1));
		sum    = {1'b0, mask} + {1'b0, low};
		run    = mask & ~sum[PIX_W-1:0];
		f.maxv = run >> f.shift;
		return f;
	endfunction

	// Several restoring division steps; rem stays below d.
	function automatic div_step_t div_steps(input logic [EXT_W-1:0] rem,
			input logic [DIV_BITS-1:0] bits, input logic [EXT_W-1:0] d);
		div_step_t r;
		logic [EXT_W:0] t;
		r.rem   = rem;
		r.qbits = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			t = {r.rem, bits[i]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				r.qbits[i] = 1'b1;
			end
			r.rem = t[EXT_W-1:0];
		end
		return r;
	endfunction
endpackage

### src/rrp_chan.sv
// One color channel: multiply by the field maximum, then a pipelined
// restoring divide by the full scale, with saturation. Uses rrp_pkg.
`timescale 1ns / 1ps
module rrp_chan (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rrp_pkg::EXT_W-1:0] v,
	input  logic [rrp_pkg::PIX_W-1:0] maxv,
	input  logic [rrp_pkg::EXT_W-1:0] d,
	output logic [rrp_pkg::PIX_W-1:0] q
);
	import rrp_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic              sat_s1;
	logic [EXT_W-1:0]  rem_s  [DIV_STAGES+1];
	logic [PIX_W-1:0]  low_s  [DIV_STAGES+1];
	logic [PIX_W-1:0]  quo_s  [DIV_STAGES+1];
	logic              sat_s  [DIV_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(v) * PROD_W'(maxv);
			sat_s1  <= (d == '0) || (v >= d);
		end
	end

	assign rem_s[0] = prod_s1[PROD_W-1:PIX_W];
	assign low_s[0] = prod_s1[PIX_W-1:0];
	assign quo_s[0] = '0;
	assign sat_s[0] = sat_s1;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_step_t st;
		assign st = div_steps(rem_s[k], low_s[k][PIX_W-1 -: DIV_BITS], d);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= st.rem;
				low_s[k+1] <= low_s[k] << DIV_BITS;
				quo_s[k+1] <= {quo_s[k][PIX_W-DIV_BITS-1:0], st.qbits};
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign q = sat_s[DIV_STAGES] ? maxv : quo_s[DIV_STAGES];
endmodule

### src/rgb_rescale_pixel_pack_top.sv
// Stages: multiply, 8 divide stages, pack, from input beat to output beat.
// Throughput: one pixel per cycle unless stalled; 4-bit divide stages set the depth.
// Stall: the whole pipeline holds while the output beat waits.
// Reset: arst_n clears valids and restores the reset masks and full scales.
// Config writes are taken every cycle; derived fields settle in the cycle after.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgb_rescale_pixel_pack_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rrp_pkg::EXT_W-1:0] red_in,
	input  logic [rrp_pkg::EXT_W-1:0] green_in,
	input  logic [rrp_pkg::EXT_W-1:0] blue_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rrp_pkg::PIX_W-1:0] native_pixel,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rrp_pkg::IDX_W-1:0] cfg_index,
	input  logic [rrp_pkg::PIX_W-1:0] cfg_data
);
	import rrp_pkg::*;

	logic [PIX_W-1:0] red_mask_q, green_mask_q, blue_mask_q;
	logic [EXT_W-1:0] red_fs_q, green_fs_q, blue_fs_q;
	field_t           red_f_q, green_f_q, blue_f_q;
	logic [LAT-1:0]   vld_q;
	logic             en;
	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic [PIX_W-1:0] pixel_s;

	// Register file: always ready, unknown indexes dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= PIX_W'(32'h00FF_0000);
			green_mask_q <= PIX_W'(32'h0000_FF00);
			blue_mask_q  <= PIX_W'(32'h0000_00FF);
			red_fs_q     <= EXT_W'(255);
			green_fs_q   <= EXT_W'(255);
			blue_fs_q    <= EXT_W'(255);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RED_MASK:   red_mask_q   <= cfg_data;
				REG_GREEN_MASK: green_mask_q <= cfg_data;
				REG_BLUE_MASK:  blue_mask_q  <= cfg_data;
				REG_RED_FS:     red_fs_q     <= cfg_data[EXT_W-1:0];
				REG_GREEN_FS:   green_fs_q   <= cfg_data[EXT_W-1:0];
				REG_BLUE_FS:    blue_fs_q    <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Re-derive shift and field maximum from the stored masks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_f_q   <= '{shift: SHIFT_W'(16), maxv: PIX_W'(255)};
			green_f_q <= '{shift: SHIFT_W'(8),  maxv: PIX_W'(255)};
			blue_f_q  <= '{shift: SHIFT_W'(0),  maxv: PIX_W'(255)};
		end else begin
			red_f_q   <= decode_mask(red_mask_q);
			green_f_q <= decode_mask(green_mask_q);
			blue_f_q  <= decode_mask(blue_mask_q);
		end
	end

	// Advance every stage together unless the output beat is stuck.
	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	rrp_chan u_red (
		.clk(clk), .en(en), .v(red_in), .maxv(red_f_q.maxv), .d(red_fs_q), .q(red_q)
	);
	rrp_chan u_green (
		.clk(clk), .en(en), .v(green_in), .maxv(green_f_q.maxv), .d(green_fs_q),
		.q(green_q)
	);
	rrp_chan u_blue (
		.clk(clk), .en(en), .v(blue_in), .maxv(blue_f_q.maxv), .d(blue_fs_q), .q(blue_q)
	);

	// Pack: place each channel at its field and merge.
	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s <= (red_q << red_f_q.shift) | (green_q << green_f_q.shift)
				| (blue_q << blue_f_q.shift);
		end
	end

	assign out_valid    = vld_q[LAT-1];
	assign native_pixel = pixel_s;

	`ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_q[0], "accepted beat lost at entry")
	`ASSERT_SAME(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken during stall")
	`ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, $stable(vld_q), "pipeline moved in stall")
endmodule

### tb/tb_rgb_rescale_pixel_pack_top.sv
// Testbench for rgb_rescale_pixel_pack_top: drives RGB triples and mask and
// full-scale writes, predicts each packed pixel, and checks it. Needs rrp_pkg.
`timescale 1ns / 1ps
module tb_rgb_rescale_pixel_pack_top;
	import rrp_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [EXT_W-1:0]  red_in = '0, green_in = '0, blue_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PIX_W-1:0]  native_pixel;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [PIX_W-1:0]  cfg_data = '0;

	rgb_rescale_pixel_pack_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the configuration and what the block derives from it.
	logic [PIX_W-1:0] chan_mask [3];
	logic [EXT_W-1:0] full_scale [3];
	int unsigned      chan_shift [3];
	logic [63:0]      chan_max [3];

	logic [PIX_W-1:0] pixel_queue [$];
	int               errors = 0;
	int               beats_checked = 0;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	bit               hold_off = 1'b0;

	// Trailing zeros and the maximum value of the lowest run of ones.
	task automatic derive_field(input int c);
		int pos, len;
		pos = 0;
		len = 0;
		if (chan_mask[c] == '0) begin
			chan_shift[c] = 0;
			chan_max[c] = 0;
		end else begin
			while (pos < PIX_W && !chan_mask[c][pos]) pos++;
			while (pos + len < PIX_W && chan_mask[c][pos + len]) len++;
			chan_shift[c] = pos;
			chan_max[c] = (64'd1 << len) - 64'd1;
		end
	endtask

	function automatic logic [63:0] scaled_channel(input logic [EXT_W-1:0] v, input int c);
		logic [127:0] prod;
		if (full_scale[c] == '0 || v >= full_scale[c]) return chan_max[c];
		prod = 128'(v) * 128'(chan_max[c]);
		return 64'(prod / 128'(full_scale[c]));
	endfunction

	function automatic logic [PIX_W-1:0] packed_pixel(input logic [EXT_W-1:0] r,
			input logic [EXT_W-1:0] g, input logic [EXT_W-1:0] b);
		logic [127:0] px;
		px = (128'(scaled_channel(r, 0)) << chan_shift[0]) |
			(128'(scaled_channel(g, 1)) << chan_shift[1]) |
			(128'(scaled_channel(b, 2)) << chan_shift[2]);
		return px[PIX_W-1:0];
	endfunction

	// Output side: random stall, optional long hold-off, check each beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pixel_queue.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, actual %h",
						$time, native_pixel);
					errors++;
				end else begin
					if (native_pixel !== pixel_queue[0]) begin
						$display("%0t: native_pixel expected %h, actual %h",
							$time, pixel_queue[0], native_pixel);
						errors++;
					end
					void'(pixel_queue.pop_front());
					beats_checked++;
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Send one triple; the expectation is queued at the accepting edge.
	// Valid stays high into the next beat unless the sender idles.
	task automatic send_pixel(input logic [EXT_W-1:0] r, input logic [EXT_W-1:0] g,
			input logic [EXT_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (!in_ready);
		pixel_queue.push_back(packed_pixel(r, g, b));
	endtask

	// Drop valid, drain, then let the pipeline go quiet before touching registers.
	task automatic drain;
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pixel_queue.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PIX_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_BLUE_MASK) begin
			chan_mask[idx] = data;
			derive_field(idx);
		end else begin
			full_scale[idx - REG_RED_FS] = data[EXT_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic load_config(input logic [PIX_W-1:0] rm, input logic [PIX_W-1:0] gm,
			input logic [PIX_W-1:0] bm, input logic [EXT_W-1:0] rf,
			input logic [EXT_W-1:0] gf, input logic [EXT_W-1:0] bf);
		drain();
		write_reg(REG_RED_MASK, rm);
		write_reg(REG_GREEN_MASK, gm);
		write_reg(REG_BLUE_MASK, bm);
		write_reg(REG_RED_FS, PIX_W'(rf));
		write_reg(REG_GREEN_FS, PIX_W'(gf));
		write_reg(REG_BLUE_FS, PIX_W'(bf));
	endtask

	function automatic logic [EXT_W-1:0] pick_value(input logic [EXT_W-1:0] fs);
		case ($urandom_range(9))
			0: return '0;
			1: return fs;
			2: return 16'($urandom);
			default: return (fs == 0) ? 16'($urandom) : 16'($urandom_range(fs));
		endcase
	endfunction

	// Directed: extremes, above full scale, default masks.
	task automatic test_directed;
		send_pixel('0, '0, '0);
		send_pixel(16'd255, 16'd255, 16'd255);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'd128, 16'd1, 16'd254);
		send_pixel(16'hAAAA, 16'h5555, 16'h0100);
		send_pixel(16'h5555, 16'hAAAA, 16'h00FF);
	endtask

	// Zero masks, split masks, all-ones mask and full scale extremes.
	task automatic test_special_masks;
		load_config('0, 32'h0000FFF0, 32'h0F0F0000, 16'd1, 16'hFFFF, 16'd0);
		send_pixel(16'hFFFF, 16'h8000, 16'd3);
		send_pixel('0, 16'hFFFF, '0);
		send_pixel(16'd1, 16'h1234, 16'hFFFF);
		load_config(32'hFFFFFFFF, '0, '0, 16'hFFFF, 16'd1, 16'd1);
		send_pixel(16'hFFFF, 16'd1, 16'd1);
		send_pixel(16'h7FFF, '0, '0);
		send_pixel(16'd1, '0, '0);
		load_config(32'h80000000, 32'h00000001, 32'h7FFFFFFE, 16'd2, 16'd3, 16'd65534);
		send_pixel(16'd1, 16'd2, 16'd65533);
		send_pixel(16'd2, 16'd0, 16'hFFFF);
	endtask

	task automatic random_burst(input int n);
		repeat (n)
			send_pixel(pick_value(full_scale[0]), pick_value(full_scale[1]),
				pick_value(full_scale[2]));
	endtask

	// Random masks and full scales, run through each idling phase.
	task automatic test_random;
		int phase;
		for (phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			load_config($urandom, $urandom, $urandom,
				($urandom_range(3) == 0) ? 16'($urandom_range(1, 15)) : 16'($urandom),
				16'($urandom), ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom));
			random_burst(105);
		end
	endtask

	// Hold the output off long enough that the pipeline fills and backs up.
	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_config(32'h00FF0000, 32'h0000FF00, 32'h000000FF, 16'd255, 16'd255, 16'd255);
		fork
			begin
				int n;
				hold_off = 1'b1;
				for (n = 0; n < 200; n++) @(posedge clk);
				hold_off = 1'b0;
			end
			random_burst(60);
		join
	endtask

	initial begin
		chan_mask = '{32'h00FF0000, 32'h0000FF00, 32'h000000FF};
		full_scale = '{16'd255, 16'd255, 16'd255};
		for (int c = 0; c < 3; c++) derive_field(c);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_special_masks();
		test_backpressure();
		test_random();
		drain();
		$display("Covered %0d pixels: default, zero, split and full-width masks,",
			beats_checked);
		$display("full scales 0 to 65535, idle and stall phases and a long hold-off.");
		if (errors == 0 && pixel_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
